### hw/rtl/uvje_pkg.sv
// Shared types and constants of the UTF-8 validating JSON escaper.
// Holds the command word passed from the front end to the back end, the
// configuration record and the register indices. No dependencies.
`default_nettype none

package uvje_pkg;

   // Register indices of the configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_UTF8       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACE_INVALID  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_NON_ASCII = 2'd2;

   // Depth of the command queue between front and back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Characters used by the escaper.
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [15:0] REPL_CODE = 16'hFFFD;

   typedef struct packed {
      logic check_utf8;
      logic replace_invalid;
      logic escape_non_ascii;
   } cfg_type;

   // Body of a command, emitted after the optional quote and replacements.
   typedef enum logic [3:0] {
      MK_NONE,
      MK_BYTE1,
      MK_ESC2,
      MK_HEX4,
      MK_RAW2,
      MK_RAW3,
      MK_FAIL,
      MK_CLOSE,
      MK_CLOSE_ERR
   } main_kind_type;

   typedef struct packed {
      logic          quote;       // opening quote first
      logic [1:0]    repl_count;  // number of U+FFFD replacements
      logic          repl_esc;    // replacements as \ufffd
      main_kind_type kind;
      logic [23:0]   payload;     // bytes low first, or a 16-bit code point
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       closes_string;
      logic       error;
   } rsp_type;

   typedef enum logic [1:0] {
      SEG_QUOTE,
      SEG_REPL,
      SEG_MAIN
   } seg_type;

endpackage

`default_nettype wire

### hw/rtl/uvje_if.sv
// Valid/ready channel interfaces for the request and response sides of
// the JSON escaper. No dependencies.
`default_nettype none

interface uvje_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] byte_in;

   modport source (output valid, action, byte_in, input ready);
   modport sink   (input valid, action, byte_in, output ready);
endinterface

interface uvje_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       closes_string;
   logic       error;

   modport source  (output valid, out_byte, last_of_run, closes_string, error,
                    input ready);
   modport sink    (input valid, out_byte, last_of_run, closes_string, error,
                    output ready);
   modport monitor (input valid, ready, out_byte, last_of_run, closes_string,
                    error);
endinterface

`default_nettype wire

### hw/rtl/uvje_front.sv
// Front end of the JSON escaper: configuration registers, string state and
// UTF-8 classification. Turns each request into at most one command word.
// Depends on uvje_pkg.
`default_nettype none

module uvje_front import uvje_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_wdata,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   in_action,
   input  logic [7:0]             in_byte,
   input  logic                   queue_full,
   output logic                   push,
   output cmd_type                cmd
);

   cfg_type    cfg_ff, cfg_in;
   logic       quote_opened_ff, quote_opened_in;
   logic [1:0] pending_count_ff, pending_count_in;
   logic [7:0] pending_lead_ff, pending_lead_in;
   logic [7:0] pending_second_ff, pending_second_in;
   logic       string_failed_ff, string_failed_in;
   logic       accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHECK_UTF8:       cfg_in.check_utf8       = csr_wdata;
            CSR_REPLACE_INVALID:  cfg_in.replace_invalid  = csr_wdata;
            CSR_ESCAPE_NON_ASCII: cfg_in.escape_non_ascii = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic        checking;
      logic        cont;
      logic        do_fresh;
      logic        stored;
      logic        ok;
      logic [10:0] d2;
      logic [15:0] d3;

      checking = cfg_ff.check_utf8 | cfg_ff.replace_invalid | cfg_ff.escape_non_ascii;
      cont     = (in_byte[7:6] == 2'b10);
      do_fresh = 1'b0;
      stored   = 1'b0;
      ok       = 1'b0;
      d2       = {pending_lead_ff[4:0], in_byte[5:0]};
      d3       = {pending_lead_ff[3:0], pending_second_ff[5:0], in_byte[5:0]};

      cmd.quote      = 1'b0;
      cmd.repl_count = 2'd0;
      cmd.repl_esc   = cfg_ff.escape_non_ascii;
      cmd.kind       = MK_NONE;
      cmd.payload    = '0;

      quote_opened_in   = quote_opened_ff;
      pending_count_in  = pending_count_ff;
      pending_lead_in   = pending_lead_ff;
      pending_second_in = pending_second_ff;
      string_failed_in  = string_failed_ff;

      if (in_action) begin
         // End of string: flush a held sequence, then close.
         cmd.quote = !quote_opened_ff;
         if (!string_failed_ff && pending_count_ff != 2'd0 && cfg_ff.replace_invalid) begin
            cmd.repl_count = (pending_count_ff >= 2'd2) ? 2'd2 : 2'd1;
         end
         if (string_failed_ff || (pending_count_ff != 2'd0 && !cfg_ff.replace_invalid)) begin
            cmd.kind = MK_CLOSE_ERR;
         end else begin
            cmd.kind = MK_CLOSE;
         end
         quote_opened_in  = 1'b0;
         pending_count_in = 2'd0;
         string_failed_in = 1'b0;
      end else if (!string_failed_ff) begin
         if (!quote_opened_ff) begin
            cmd.quote       = 1'b1;
            quote_opened_in = 1'b1;
         end
         if (pending_count_ff == 2'd1) begin
            if (cont && pending_lead_ff[7:5] != 3'b110) begin
               stored            = 1'b1;
               pending_second_in = in_byte;
               pending_count_in  = 2'd2;
            end else begin
               ok = cont && (d2 >= 11'h080);
               if (ok) begin
                  pending_count_in = 2'd0;
                  if (cfg_ff.escape_non_ascii) begin
                     cmd.kind    = MK_HEX4;
                     cmd.payload = {13'h0000, d2};
                  end else begin
                     cmd.kind    = MK_RAW2;
                     cmd.payload = {8'h00, in_byte, pending_lead_ff};
                  end
               end
            end
         end else if (pending_count_ff != 2'd0) begin
            ok = cont && (pending_lead_ff[7:4] == 4'hE) && (d3 >= 16'h0800)
                 && (d3[15:11] != 5'b11011);
            if (ok) begin
               pending_count_in = 2'd0;
               if (cfg_ff.escape_non_ascii) begin
                  cmd.kind    = MK_HEX4;
                  cmd.payload = {8'h00, d3};
               end else begin
                  cmd.kind    = MK_RAW3;
                  cmd.payload = {in_byte, pending_second_ff, pending_lead_ff};
               end
            end
         end else begin
            do_fresh = 1'b1;
         end

         // A held sequence that was broken by this byte.
         if (pending_count_ff != 2'd0 && !stored && !ok) begin
            pending_count_in = 2'd0;
            if (cfg_ff.replace_invalid) begin
               cmd.repl_count = (pending_count_ff >= 2'd2) ? 2'd2 : 2'd1;
               do_fresh       = 1'b1;
            end else begin
               string_failed_in = 1'b1;
               cmd.kind         = MK_FAIL;
            end
         end

         if (do_fresh) begin
            if (!in_byte[7]) begin
               case (in_byte)
                  8'h22, 8'h5C: begin
                     cmd.kind    = MK_ESC2;
                     cmd.payload = {16'h0000, in_byte};
                  end
                  8'h08: begin cmd.kind = MK_ESC2; cmd.payload = {16'h0000, 8'h62}; end
                  8'h0C: begin cmd.kind = MK_ESC2; cmd.payload = {16'h0000, 8'h66}; end
                  8'h0A: begin cmd.kind = MK_ESC2; cmd.payload = {16'h0000, 8'h6E}; end
                  8'h0D: begin cmd.kind = MK_ESC2; cmd.payload = {16'h0000, 8'h72}; end
                  8'h09: begin cmd.kind = MK_ESC2; cmd.payload = {16'h0000, 8'h74}; end
                  default: begin
                     if (in_byte < 8'h20) begin
                        cmd.kind    = MK_HEX4;
                        cmd.payload = {16'h0000, in_byte};
                     end else begin
                        cmd.kind    = MK_BYTE1;
                        cmd.payload = {16'h0000, in_byte};
                     end
                  end
               endcase
            end else if (!checking) begin
               cmd.kind    = MK_BYTE1;
               cmd.payload = {16'h0000, in_byte};
            end else if (in_byte[7:6] != 2'b11) begin
               if (cfg_ff.replace_invalid) begin
                  cmd.repl_count = cmd.repl_count + 2'd1;
               end else begin
                  string_failed_in = 1'b1;
                  pending_count_in = 2'd0;
                  cmd.kind         = MK_FAIL;
               end
            end else begin
               pending_lead_in  = in_byte;
               pending_count_in = 2'd1;
            end
         end
      end
   end

   assign push = accept && (cmd.quote || cmd.repl_count != 2'd0 || cmd.kind != MK_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         quote_opened_ff  <= 1'b0;
         pending_count_ff <= 2'd0;
         string_failed_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            quote_opened_ff  <= quote_opened_in;
            pending_count_ff <= pending_count_in;
            string_failed_ff <= string_failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pending_lead_ff   <= pending_lead_in;
         pending_second_ff <= pending_second_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/uvje_queue.sv
// Short command queue between the front and back ends of the escaper.
// Register based, one write and one read per cycle. Depends on uvje_pkg.
`default_nettype none

module uvje_queue import uvje_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/uvje_back.sv
// Back end of the JSON escaper: expands the command at the queue head into
// output bytes, one per cycle while the output is not stalled, through a registered output stage.
// Depends on uvje_pkg.
`default_nettype none

module uvje_back import uvje_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  cmd_type head,
   output logic    pop,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
   endfunction

   function automatic logic [7:0] hex4_byte(input logic [2:0] idx, input logic [15:0] code);
      logic [7:0] b;
      case (idx)
         3'd0:    b = CH_BSLASH;
         3'd1:    b = CH_U;
         3'd2:    b = hex_char(code[15:12]);
         3'd3:    b = hex_char(code[11:8]);
         3'd4:    b = hex_char(code[7:4]);
         default: b = hex_char(code[3:0]);
      endcase
      return b;
   endfunction

   seg_type    seg_ff, seg_in;
   logic [2:0] idx_ff, idx_in;
   logic [1:0] rep_ff, rep_in;
   logic       fresh_ff, fresh_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;

   seg_type    cur_seg, first_seg, next_seg;
   logic [2:0] cur_idx, seg_len;
   logic [1:0] cur_rep, next_rep;
   logic       seg_end, more_repl, has_main, last, load;
   rsp_type    beat;

   assign first_seg = head.quote ? SEG_QUOTE :
                      ((head.repl_count != 2'd0) ? SEG_REPL : SEG_MAIN);
   assign cur_seg   = fresh_ff ? first_seg : seg_ff;
   assign cur_idx   = fresh_ff ? 3'd0 : idx_ff;
   assign cur_rep   = fresh_ff ? 2'd0 : rep_ff;

   always_comb begin
      seg_len            = 3'd1;
      beat.out_byte      = 8'h00;
      beat.closes_string = 1'b0;
      beat.error         = 1'b0;
      case (cur_seg)
         SEG_QUOTE: beat.out_byte = CH_QUOTE;
         SEG_REPL: begin
            if (head.repl_esc) begin
               seg_len       = 3'd6;
               beat.out_byte = hex4_byte(cur_idx, REPL_CODE);
            end else begin
               seg_len       = 3'd3;
               beat.out_byte = (cur_idx == 3'd0) ? 8'hEF :
                               ((cur_idx == 3'd1) ? 8'hBF : 8'hBD);
            end
         end
         SEG_MAIN: begin
            case (head.kind)
               MK_BYTE1: beat.out_byte = head.payload[7:0];
               MK_ESC2: begin
                  seg_len       = 3'd2;
                  beat.out_byte = (cur_idx == 3'd0) ? CH_BSLASH : head.payload[7:0];
               end
               MK_HEX4: begin
                  seg_len       = 3'd6;
                  beat.out_byte = hex4_byte(cur_idx, head.payload[15:0]);
               end
               MK_RAW2, MK_RAW3: begin
                  seg_len       = (head.kind == MK_RAW2) ? 3'd2 : 3'd3;
                  beat.out_byte = (cur_idx == 3'd0) ? head.payload[7:0] :
                                  ((cur_idx == 3'd1) ? head.payload[15:8] : head.payload[23:16]);
               end
               MK_FAIL: beat.error = 1'b1;
               MK_CLOSE: begin
                  beat.out_byte      = CH_QUOTE;
                  beat.closes_string = 1'b1;
               end
               MK_CLOSE_ERR: begin
                  beat.closes_string = 1'b1;
                  beat.error         = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      seg_end = (cur_idx == seg_len - 3'd1);
      case (cur_seg)
         SEG_QUOTE: more_repl = (head.repl_count != 2'd0);
         SEG_REPL:  more_repl = ({1'b0, cur_rep} + 3'd1) < {1'b0, head.repl_count};
         default:   more_repl = 1'b0;
      endcase
      has_main = (head.kind != MK_NONE) && (cur_seg != SEG_MAIN);
      last     = seg_end && !more_repl && !has_main;
      beat.last_of_run = last;

      if (more_repl) begin
         next_seg = SEG_REPL;
         next_rep = (cur_seg == SEG_REPL) ? cur_rep + 2'd1 : 2'd0;
      end else begin
         next_seg = SEG_MAIN;
         next_rep = 2'd0;
      end
   end

   assign load = head_valid && (!out_valid_ff || out_ready);
   assign pop  = load && last;

   always_comb begin
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      rep_in       = rep_ff;
      fresh_in     = fresh_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !out_ready;
      if (load) begin
         out_valid_in = 1'b1;
         out_data_in  = beat;
         if (last) begin
            fresh_in = 1'b1;
         end else if (seg_end) begin
            fresh_in = 1'b0;
            seg_in   = next_seg;
            idx_in   = 3'd0;
            rep_in   = next_rep;
         end else begin
            fresh_in = 1'b0;
            seg_in   = cur_seg;
            idx_in   = cur_idx + 3'd1;
            rep_in   = cur_rep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= SEG_QUOTE;
         idx_ff       <= 3'd0;
         rep_ff       <= 2'd0;
         fresh_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         rep_ff       <= rep_in;
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

### hw/rtl/utf8_validating_json_escaper_unit.sv
// Top level of the UTF-8 validating JSON escaper.
// Depends on uvje_pkg, uvje_if, uvje_front, uvje_queue and uvje_back.
//
// The block takes the bytes of one string as requests, each followed by an
// end request, and returns the JSON-quoted text one byte per response, with
// last_of_run marking the final byte caused by a request. One request is
// accepted per clock cycle as long as the command queue has room; the
// output side delivers one byte per cycle while the response side is ready,
// so a request that expands to N bytes (an escape is 2 or 6 bytes, a U+FFFD
// replacement 3 or 6 bytes, up to 18 bytes in all) holds the response channel
// until all N are taken, and the sustained request rate is one per cycle
// only while each request yields at most one byte. The two-entry command
// queue between the classifying front end and the expanding back end lets
// requests keep arriving while earlier escapes drain. When the queue is
// empty, a request's command is written into the queue entry when it is
// accepted and its first byte is then loaded into the response register,
// from which it can be taken. There is no clearing pass after reset.
`default_nettype none

module utf8_validating_json_escaper_unit import uvje_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   uvje_req_if.sink               req_chan,
   uvje_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_wdata
);

   // Command word handed from the front end to the queue, and the queue head
   // seen by the back end.
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    push;
   logic    queue_full;
   logic    head_valid;
   logic    pop;
   rsp_type rsp_data;

   // The front end keeps the per-string state (quote opened, held UTF-8
   // sequence, failed string) and the three configuration bits. Each
   // accepted request becomes at most one command; a request that produces
   // no bytes, such as a held lead byte, pushes nothing.
   uvje_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_action  (req_chan.action),
      .in_byte    (req_chan.byte_in),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   // The queue decouples the two halves, so that neither stalls the other
   // for longer than the queue is full or empty.
   uvje_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head_cmd)
   );

   // The back end walks the segments of the head command (opening quote,
   // replacements, body) into its output register, one byte per cycle when
   // not stalled, and pops the command as its last byte is loaded.
   uvje_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head_cmd),
      .pop        (pop),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_data   (rsp_data)
   );

   assign rsp_chan.out_byte      = rsp_data.out_byte;
   assign rsp_chan.last_of_run   = rsp_data.last_of_run;
   assign rsp_chan.closes_string = rsp_data.closes_string;
   assign rsp_chan.error         = rsp_data.error;

endmodule

`default_nettype wire

### hw/rtl/uvje_checker.sv
// Port-level assertions for the JSON escaper, bound to the top level.
// Depends on uvje_pkg.
`default_nettype none

module uvje_checker import uvje_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run,
   input logic       rsp_closes_string,
   input logic       rsp_error
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_out_byte) && $stable(rsp_last_of_run)
         && $stable(rsp_closes_string) && $stable(rsp_error))
      else $error("response changed while stalled");

   // Error markers carry a zero byte.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_out_byte == 8'h00)
      else $error("error marker with non-zero byte");

   // The byte that closes a string is always the final one of its request.
   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closes_string |-> rsp_last_of_run)
      else $error("closing byte not last of run");

   // A good string closes with a quote.
   a_close_quote: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closes_string && !rsp_error
         |-> rsp_out_byte == CH_QUOTE)
      else $error("string closed without a quote");

endmodule

bind utf8_validating_json_escaper_unit uvje_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_out_byte      (rsp_chan.out_byte),
   .rsp_last_of_run   (rsp_chan.last_of_run),
   .rsp_closes_string (rsp_chan.closes_string),
   .rsp_error         (rsp_chan.error)
);

`default_nettype wire

### dv/utf8_validating_json_escaper_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the UTF-8 validating JSON escaper.
// Depends on uvje_pkg and the uvje_req_if / uvje_rsp_if channel interfaces. A scoreboard
// class predicts the escaped text of every accepted request and checks each response.

module utf8_validating_json_escaper_unit_tb;
   import uvje_pkg::*;

   // Kinds of request on the input channel.
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   // An index the block has no register for; a write to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = 2'd3;

   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int ROUNDS          = 8;
   localparam int ROUND_REQUESTS  = 11;
   localparam int CYCLE_LIMIT     = 500000;

   // Scoreboard: keeps its own copy of the escaper state and settings, turns every
   // accepted request into the bytes it should produce and checks them in order.
   class escape_scoreboard;
      cfg_type    cfg;
      logic       quote_opened;
      logic [1:0] held_count;
      logic [7:0] held_lead;
      logic [7:0] held_second;
      logic       string_failed;
      rsp_type    run_text[$];
      rsp_type    expected_text[$];
      int         mismatch_count;

      function new();
         cfg           = '0;
         quote_opened  = 1'b0;
         held_count    = 2'd0;
         held_lead     = 8'h00;
         held_second   = 8'h00;
         string_failed = 1'b0;
         mismatch_count = 0;
      endfunction

      function void write_config(logic [CSR_INDEX_W-1:0] index, logic value);
         case (index)
            CSR_CHECK_UTF8:       cfg.check_utf8       = value;
            CSR_REPLACE_INVALID:  cfg.replace_invalid  = value;
            CSR_ESCAPE_NON_ASCII: cfg.escape_non_ascii = value;
            default: ;
         endcase
      endfunction

      function void push_byte(logic [7:0] b, logic closes = 1'b0, logic err = 1'b0);
         rsp_type r;
         r.out_byte      = b;
         r.last_of_run   = 1'b0;
         r.closes_string = closes;
         r.error         = err;
         run_text = {run_text, r};
      endfunction

      function logic [7:0] hex_digit(logic [3:0] n);
         logic [7:0] v;
         v = {4'h0, n};
         return (n < 4'd10) ? v + "0" : v + "a" - 8'd10;
      endfunction

      function void push_code_point(logic [15:0] cp);
         push_byte(CH_BSLASH);
         push_byte(CH_U);
         push_byte(hex_digit(cp[15:12]));
         push_byte(hex_digit(cp[11:8]));
         push_byte(hex_digit(cp[7:4]));
         push_byte(hex_digit(cp[3:0]));
      endfunction

      function void push_replacement();
         if (cfg.escape_non_ascii) begin
            push_code_point(REPL_CODE);
         end else begin
            push_byte(8'hEF);
            push_byte(8'hBF);
            push_byte(8'hBD);
         end
      endfunction

      function void abort_string();
         string_failed = 1'b1;
         held_count    = 2'd0;
         push_byte(8'h00, 1'b0, 1'b1);
      endfunction

      function void push_ascii(logic [7:0] x);
         case (x)
            CH_QUOTE, CH_BSLASH: begin push_byte(CH_BSLASH); push_byte(x);   end
            8'h08:               begin push_byte(CH_BSLASH); push_byte("b"); end
            8'h0C:               begin push_byte(CH_BSLASH); push_byte("f"); end
            8'h0A:               begin push_byte(CH_BSLASH); push_byte("n"); end
            8'h0D:               begin push_byte(CH_BSLASH); push_byte("r"); end
            8'h09:               begin push_byte(CH_BSLASH); push_byte("t"); end
            default: begin
               if (x < 8'h20) begin
                  push_byte(CH_BSLASH);
                  push_byte(CH_U);
                  push_byte("0");
                  push_byte("0");
                  push_byte(hex_digit(x[7:4]));
                  push_byte(hex_digit(x[3:0]));
               end else begin
                  push_byte(x);
               end
            end
         endcase
      endfunction

      // A byte arriving with no multi-byte sequence open.
      function void take_fresh(logic [7:0] x);
         if (x < 8'h80) begin
            push_ascii(x);
         end else if (!(cfg.check_utf8 | cfg.replace_invalid | cfg.escape_non_ascii)) begin
            push_byte(x);
         end else if (x[7:6] != 2'b11) begin
            if (cfg.replace_invalid) push_replacement();
            else abort_string();
         end else begin
            held_lead  = x;
            held_count = 2'd1;
         end
      endfunction

      // The open sequence cannot complete; tells whether the breaking byte is still used.
      function bit drop_sequence();
         if (cfg.replace_invalid) begin
            push_replacement();
            if (held_count >= 2'd2) push_replacement();
            held_count = 2'd0;
            return 1'b1;
         end
         abort_string();
         return 1'b0;
      endfunction

      // A byte arriving while a sequence is open.
      function void take_held(logic [7:0] x);
         logic [15:0] cp;
         logic        cont;
         logic        ok;
         cont = (x[7:6] == 2'b10);
         if (held_count == 2'd1) begin
            if (cont && held_lead[7:5] != 3'b110) begin
               held_second = x;
               held_count  = 2'd2;
               return;
            end
            cp = {5'b0, held_lead[4:0], x[5:0]};
            ok = cont && cp >= 16'h0080;
            if (ok) begin
               held_count = 2'd0;
               if (cfg.escape_non_ascii) begin
                  push_code_point(cp);
               end else begin
                  push_byte(held_lead);
                  push_byte(x);
               end
               return;
            end
         end else begin
            cp = {held_lead[3:0], held_second[5:0], x[5:0]};
            ok = cont && held_lead[7:4] == 4'hE && cp >= 16'h0800
                 && !(cp >= 16'hD800 && cp <= 16'hDFFF);
            if (ok) begin
               held_count = 2'd0;
               if (cfg.escape_non_ascii) begin
                  push_code_point(cp);
               end else begin
                  push_byte(held_lead);
                  push_byte(held_second);
                  push_byte(x);
               end
               return;
            end
         end
         if (drop_sequence()) take_fresh(x);
      endfunction

      function void note_request(logic action, logic [7:0] x);
         run_text.delete();
         if (action == ACT_END) begin
            if (!quote_opened) push_byte(CH_QUOTE);
            if (!string_failed && held_count != 2'd0) begin
               if (cfg.replace_invalid) begin
                  push_replacement();
                  if (held_count >= 2'd2) push_replacement();
               end else begin
                  string_failed = 1'b1;
               end
            end
            if (string_failed) push_byte(8'h00, 1'b1, 1'b1);
            else push_byte(CH_QUOTE, 1'b1, 1'b0);
            quote_opened  = 1'b0;
            held_count    = 2'd0;
            string_failed = 1'b0;
         end else if (!string_failed) begin
            if (!quote_opened) begin
               push_byte(CH_QUOTE);
               quote_opened = 1'b1;
            end
            if (held_count != 2'd0) take_held(x);
            else take_fresh(x);
         end
         if (run_text.size() > 0) run_text[run_text.size() - 1].last_of_run = 1'b1;
         expected_text = {expected_text, run_text};
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_text.size() == 0) begin
            $display("%0t: response with nothing expected: byte %h last %b closes %b error %b",
                     $time, got.out_byte, got.last_of_run, got.closes_string, got.error);
            mismatch_count++;
            return;
         end
         want = expected_text[0];
         expected_text.delete(0);
         if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run ||
             got.closes_string !== want.closes_string || got.error !== want.error) begin
            $display("%0t: mismatch: expected byte %h last %b closes %b error %b,",
                     $time, want.out_byte, want.last_of_run, want.closes_string,
                     want.error, " got byte %h last %b closes %b error %b",
                     got.out_byte, got.last_of_run, got.closes_string, got.error);
            mismatch_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_wdata;

   uvje_req_if req_if();
   uvje_rsp_if rsp_if();

   escape_scoreboard sb = new();

   // Idling of both sides, set per phase by the stimulus; percentages of cycles.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int send_idle_table[4]  = '{0, 76, 0, 30};
   int recv_stall_table[4] = '{0, 0, 76, 30};
   bit hold_off_req   = 1'b0;
   int requests_sent  = 0;
   int cycle_count    = 0;

   utf8_validating_json_escaper_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Both channels are sampled at the rising edge, before any of this edge's updates land,
   // so a request is noted and a response checked exactly when its handshake completes.
   // A response can never stem from a request accepted at the same edge, so the order of
   // the two calls below does not matter.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         sb.note_request(req_if.action, req_if.byte_in);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_response({rsp_if.out_byte, rsp_if.last_of_run,
                            rsp_if.closes_string, rsp_if.error});
      end
   end

   // Watchdog: the slowest correct run is far below this limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d responses outstanding",
                  $time, sb.expected_text.size());
         $display("FAIL utf8_validating_json_escaper_unit");
         $finish;
      end
   end

   // Response side pacing. Normally ready is drawn afresh each cycle; when a hold-off is
   // requested, ready stays low for a long count of cycles while the sender carries on,
   // so that the command queue fills and the block has to stall its request side.
   initial begin : receiver_pacing
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offers one request and returns at the edge where it is taken. Valid is left high so
   // that a following request can go out back to back; when the sender is to idle, valid
   // drops at that same edge and the gap runs before returning.
   task automatic send_request(input logic action, input logic [7:0] b);
      req_if.valid   <= 1'b1;
      req_if.action  <= action;
      req_if.byte_in <= b;
      do @(posedge clock); while (!req_if.ready);
      requests_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Lowers valid, lets the last accepted request be noted, and waits until every
   // predicted response has come back, then a few more cycles, since requests that
   // produce nothing may still be in the pipeline.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A register write is a one-cycle strobe of the enable.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input logic value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_config(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic check, input logic replace,
                                 input logic escape);
      write_register(CSR_CHECK_UTF8, check);
      write_register(CSR_REPLACE_INVALID, replace);
      write_register(CSR_ESCAPE_NON_ASCII, escape);
   endtask

   // Sends the given bytes as one string, closed by an end request.
   task automatic send_text(input logic [7:0] text[$]);
      foreach (text[i]) send_request(ACT_BYTE, text[i]);
      send_request(ACT_END, 8'($urandom_range(255)));
   endtask

   // One character, mostly well-formed UTF-8 with random content, sometimes broken in
   // one of the ways the checker has to catch.
   task automatic send_random_character();
      int         pick;
      logic [7:0] lead;
      logic [7:0] second;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_request(ACT_BYTE, 8'($urandom_range(8'h7F)));
      end else if (pick < 42) begin
         // Quote, backslash or a control character.
         case ($urandom_range(2))
            0:       send_request(ACT_BYTE, CH_QUOTE);
            1:       send_request(ACT_BYTE, CH_BSLASH);
            default: send_request(ACT_BYTE, 8'($urandom_range(8'h1F)));
         endcase
      end else if (pick < 60) begin
         send_request(ACT_BYTE, 8'($urandom_range(8'hDF, 8'hC2)));
         send_request(ACT_BYTE, 8'($urandom_range(8'hBF, 8'h80)));
      end else if (pick < 80) begin
         // Three bytes, avoiding overlong forms and surrogates.
         lead = 8'($urandom_range(8'hEF, 8'hE0));
         if (lead == 8'hE0) second = 8'($urandom_range(8'hBF, 8'hA0));
         else if (lead == 8'hED) second = 8'($urandom_range(8'h9F, 8'h80));
         else second = 8'($urandom_range(8'hBF, 8'h80));
         send_request(ACT_BYTE, lead);
         send_request(ACT_BYTE, second);
         send_request(ACT_BYTE, 8'($urandom_range(8'hBF, 8'h80)));
      end else begin
         case ($urandom_range(7))
            0: begin
               // Lone continuation byte.
               send_request(ACT_BYTE, 8'($urandom_range(8'hBF, 8'h80)));
            end
            1: begin
               // Four-byte lead or worse: always broken at the third byte.
               send_request(ACT_BYTE, 8'($urandom_range(8'hFF, 8'hF0)));
               send_request(ACT_BYTE, 8'($urandom_range(8'hBF, 8'h80)));
               send_request(ACT_BYTE, 8'($urandom_range(8'hBF, 8'h80)));
            end
            2: begin
               // Overlong two-byte form.
               send_request(ACT_BYTE, 8'($urandom_range(8'hC1, 8'hC0)));
               send_request(ACT_BYTE, 8'($urandom_range(8'hBF, 8'h80)));
            end
            3: begin
               // Overlong three-byte form.
               send_request(ACT_BYTE, 8'hE0);
               send_request(ACT_BYTE, 8'($urandom_range(8'h9F, 8'h80)));
               send_request(ACT_BYTE, 8'($urandom_range(8'hBF, 8'h80)));
            end
            4: begin
               // Encoded surrogate.
               send_request(ACT_BYTE, 8'hED);
               send_request(ACT_BYTE, 8'($urandom_range(8'hBF, 8'hA0)));
               send_request(ACT_BYTE, 8'($urandom_range(8'hBF, 8'h80)));
            end
            5: begin
               // Lead byte broken by an ASCII byte.
               send_request(ACT_BYTE, 8'($urandom_range(8'hEF, 8'hC2)));
               send_request(ACT_BYTE, 8'($urandom_range(8'h7F)));
            end
            6: begin
               // Two bytes of a three-byte sequence, then ASCII.
               send_request(ACT_BYTE, 8'($urandom_range(8'hEF, 8'hE1)));
               send_request(ACT_BYTE, 8'($urandom_range(8'hBF, 8'h80)));
               send_request(ACT_BYTE, 8'($urandom_range(8'h7F)));
            end
            default: begin
               // A bare lead: whatever comes next, or the end, breaks it.
               send_request(ACT_BYTE, 8'($urandom_range(8'hEF, 8'hC2)));
            end
         endcase
      end
   endtask

   task automatic send_random_string();
      int n;
      n = $urandom_range(6);
      repeat (n) send_random_character();
      send_request(ACT_END, 8'($urandom_range(255)));
   endtask

   // Unstructured requests: any byte, with end requests scattered among them.
   task automatic send_noise();
      int n;
      n = $urandom_range(5, 1);
      repeat (n) begin
         send_request(($urandom_range(4) == 0) ? ACT_END : ACT_BYTE,
                      8'($urandom_range(255)));
      end
   endtask

   task automatic random_round(input int count);
      int stop_at;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         if ($urandom_range(9) == 0) send_noise();
         else send_random_string();
      end
   endtask

   initial begin : stimulus
      logic [7:0] text[$];
      int         round;
      int         k;
      req_if.valid   <= 1'b0;
      req_if.action  <= ACT_BYTE;
      req_if.byte_in <= 8'h00;
      csr_we         <= 1'b0;
      csr_index      <= CSR_CHECK_UTF8;
      csr_wdata      <= 1'b0;
      reset          <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // A write to the unused index must be ignored: the first string still runs with
      // every option off, so all the escapes apply and high bytes pass through raw.
      write_register(CSR_INDEX_UNUSED, 1'b1);
      text = '{8'h00, CH_QUOTE, CH_BSLASH, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09,
               8'h1F, 8'h7F, 8'hFF};
      send_text(text);
      settle();

      // All options on: the smallest two-byte character, a lone continuation byte, a
      // four-byte lead broken by ASCII, a surrogate, and a lead cut short by the end.
      apply_settings(1'b1, 1'b1, 1'b1);
      text = '{8'hC2, 8'h80, 8'h80, 8'hF0, 8'h41, 8'hED, 8'hA0, 8'h80, 8'hE2};
      send_text(text);
      settle();

      // Checking without replacement: an overlong form fails the string, the byte after
      // it is dropped and the end request reports the error. Then an empty string.
      apply_settings(1'b1, 1'b0, 1'b0);
      text = '{8'hC0, 8'h80, 8'h41};
      send_text(text);
      text.delete();
      send_text(text);
      settle();

      // Random rounds walk through all eight settings, from all off to all on, and
      // through every idling pattern on the two channels.
      for (round = 0; round < ROUNDS; round++) begin
         send_idle_pct  = send_idle_table[round % 4];
         recv_stall_pct = recv_stall_table[round % 4];
         apply_settings(round[0], round[1], round[2]);
         random_round(ROUND_REQUESTS);
         settle();
      end

      // Back-pressure: control characters expand to two or six bytes each, so with the
      // response side held off the queue fills and the request side has to stall.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_settings(1'b0, 1'b0, 1'b1);
      hold_off_req = 1'b1;
      text.delete();
      for (k = 0; k < 24; k++) text = {text, 8'($urandom_range(8'h1F))};
      send_text(text);
      settle();

      if (sb.mismatch_count == 0 && sb.expected_text.size() == 0) begin
         $display("PASS utf8_validating_json_escaper_unit");
      end else begin
         $display("FAIL utf8_validating_json_escaper_unit");
      end
      $finish;
   end

endmodule
